@@ hdl/pba_pkg.sv @@
// shared types and constants of the paged bump allocator
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

  // field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned WIDE_W  = 64;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALLOC = 2'd2;

  // configuration reset values
  localparam logic [WORD_W-1:0] PAGE_SIZE_RST = 32'd65536;
  localparam logic [WORD_W-1:0] ALIGNMENT_RST = 32'd256;
  localparam logic [WORD_W-1:0] MAX_ALLOC_RST = 32'd65536;

  localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_SIZE,
    ST_RND_SIZE,
    ST_DIV_CUR,
    ST_RND_CUR,
    ST_FIT,
    ST_COMMIT,
    ST_PEAK,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

@@ hdl/pba_if.sv @@
// request, result and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface pba_req_if;
  import pba_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [WORD_W-1:0] request_size;
  modport source (output valid, output kind, output request_size, input ready);
  modport sink   (input valid, input kind, input request_size, output ready);
endinterface

interface pba_rsp_if;
  import pba_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [WORD_W-1:0] page;
  logic [WORD_W-1:0] offset;
  logic [WORD_W-1:0] reserved_size;
  logic [WIDE_W-1:0] generation;
  logic [WORD_W-1:0] allocation_count;
  logic [WIDE_W-1:0] requested_total;
  logic [WIDE_W-1:0] reserved_total;
  logic [WORD_W-1:0] pages_used;
  logic [WIDE_W-1:0] peak_reserved;
  logic [WORD_W-1:0] peak_pages;
  logic              recording_on;
  modport source (output valid, output ok, output page, output offset,
                  output reserved_size, output generation, output allocation_count,
                  output requested_total, output reserved_total, output pages_used,
                  output peak_reserved, output peak_pages, output recording_on,
                  input ready);
  modport sink   (input valid, input ok, input page, input offset,
                  input reserved_size, input generation, input allocation_count,
                  input requested_total, input reserved_total, input pages_used,
                  input peak_reserved, input peak_pages, input recording_on,
                  output ready);
endinterface

interface pba_cfg_if;
  import pba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/pba_div.sv @@
// shared iterative remainder unit, one restoring step per cycle
`timescale 1ns / 1ps
`default_nettype none
module pba_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pba_pkg::WORD_W-1:0] dividend_i,
  input  wire logic [pba_pkg::WORD_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [pba_pkg::WORD_W-1:0]     rem_o
);
  import pba_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic              run_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] dvd_q;
  logic [WORD_W-1:0] dsr_q;
  logic [WORD_W-1:0] rem_q;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] rem_d;

  // shift in the next dividend bit and subtract when it fits
  assign shifted = {rem_q, dvd_q[WORD_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign rem_d   = trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CNT_LAST);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ hdl/paged_bump_allocator_top.sv @@
// paged bump allocator: sequencer, allocation state and result register
//
// Three channels. cfg_i writes page_size (0), alignment (1), max_alloc_size (2)
// and is always ready. The user must write it only while idle (not enforced).
// req_i carries kind and request_size; rsp_o returns one result per request
// with the grant and the running statistics after that request.
// Begin, end and unused kinds go from idle straight to the output state.
// An allocate runs two remainders (size and cursor by alignment) through one
// shared bit-serial remainder unit of 32 steps each, each then rounded up;
// the fit, commit and peak steps then bring a granted allocate to its result.
// A request refused before the divider also goes straight to the output state.
// req_i.ready is high only while the sequencer is idle. The result sits in
// an output register, so a new request is accepted while an earlier result
// still waits; if rsp_o stalls the sequencer holds its finished result until
// the output register frees. Reset clears generation, page, cursor,
// statistics and peaks, turns recording off and loads the default config.
`timescale 1ns / 1ps
`default_nettype none
module paged_bump_allocator_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pba_cfg_if.sink   cfg_i,
  pba_req_if.sink   req_i,
  pba_rsp_if.source rsp_o
);
  import pba_pkg::*;

  // configuration
  logic [WORD_W-1:0] page_size_q;
  logic [WORD_W-1:0] alignment_q;
  logic [WORD_W-1:0] max_alloc_q;
  logic              cfg_ok;

  // allocation state
  logic [WIDE_W-1:0] gen_q;
  logic [WORD_W-1:0] active_page_q;
  logic [WORD_W-1:0] cursor_q;
  logic              recording_q;
  logic [WORD_W-1:0] count_q;
  logic [WIDE_W-1:0] sum_req_q;
  logic [WIDE_W-1:0] sum_res_q;
  logic [WORD_W-1:0] pages_q;
  logic [WIDE_W-1:0] peak_res_q;
  logic [WORD_W-1:0] peak_pages_q;

  // working registers of one request
  state_e            state_q, state_d;
  logic [WORD_W-1:0] size_q;
  logic [WORD_W-1:0] res_q;
  logic [WORD_W-1:0] off_q;
  logic [WORD_W-1:0] work_page_q;
  logic              ok_q;
  logic              grant_q;

  // output register
  logic              rsp_valid_q;
  logic              out_ok_q;
  logic [WORD_W-1:0] out_page_q;
  logic [WORD_W-1:0] out_off_q;
  logic [WORD_W-1:0] out_res_q;
  logic [WIDE_W-1:0] out_gen_q;
  logic [WORD_W-1:0] out_count_q;
  logic [WIDE_W-1:0] out_sum_req_q;
  logic [WIDE_W-1:0] out_sum_res_q;
  logic [WORD_W-1:0] out_pages_q;
  logic [WIDE_W-1:0] out_peak_res_q;
  logic [WORD_W-1:0] out_peak_pages_q;
  logic              out_rec_q;

  // sequencer strobes
  logic              req_fire;
  logic              pre_ok;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_dvd;
  logic [WORD_W-1:0] div_rem;
  logic              rnd_fail;
  logic              fits;
  logic              load_out;

  // shared rounding arithmetic
  logic [WORD_W-1:0] rnd_src;
  logic [WORD_W-1:0] pad;
  logic [WORD_W:0]   rnd_sum;
  logic [WORD_W-1:0] rnd_val;
  logic [WIDE_W-1:0] gen_inc;
  logic [WORD_W-1:0] used;

  assign cfg_ok = (page_size_q != '0) && (alignment_q != '0) &&
                  (alignment_q <= page_size_q) && (max_alloc_q != '0) &&
                  (max_alloc_q <= page_size_q);

  assign req_fire = req_i.valid && req_i.ready;
  assign pre_ok   = cfg_ok && recording_q && (req_i.request_size != '0) &&
                    (req_i.request_size <= max_alloc_q);

  // round size or cursor up to alignment, with overflow and size-to-page checks
  assign rnd_src = (state_q == ST_RND_SIZE) ? size_q : cursor_q;
  assign pad     = alignment_q - div_rem;
  assign rnd_sum = {1'b0, rnd_src} + {1'b0, pad};
  assign rnd_val = (div_rem == '0) ? rnd_src : rnd_sum[WORD_W-1:0];
  assign rnd_fail = ((div_rem != '0) && rnd_sum[WORD_W]) ||
                    ((state_q == ST_RND_SIZE) && (rnd_val > page_size_q));

  assign fits    = !((off_q > page_size_q) || (res_q > (page_size_q - off_q)));
  assign gen_inc = (gen_q + WIDE_W'(1) == '0) ? WIDE_W'(1) : gen_q + WIDE_W'(1);
  assign used    = work_page_q + WORD_W'(1);
  assign div_dvd = (state_q == ST_IDLE) ? req_i.request_size : cursor_q;

  // shared remainder unit
  pba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (alignment_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and strobes
  always_comb begin
    state_d     = state_q;
    div_start   = 1'b0;
    load_out    = 1'b0;
    req_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if ((req_i.kind == KIND_ALLOC) && pre_ok) begin
            div_start = 1'b1;
            state_d   = ST_DIV_SIZE;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV_SIZE: begin
        if (div_done) begin
          state_d = ST_RND_SIZE;
        end
      end
      ST_RND_SIZE: begin
        if (rnd_fail) begin
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_CUR;
        end
      end
      ST_DIV_CUR: begin
        if (div_done) begin
          state_d = ST_RND_CUR;
        end
      end
      ST_RND_CUR: begin
        state_d = rnd_fail ? ST_OUT : ST_FIT;
      end
      ST_FIT: begin
        state_d = (!fits && (active_page_q == WORD_MAX)) ? ST_OUT : ST_COMMIT;
      end
      ST_COMMIT: begin
        state_d = ST_PEAK;
      end
      ST_PEAK: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q <= PAGE_SIZE_RST;
      alignment_q <= ALIGNMENT_RST;
      max_alloc_q <= MAX_ALLOC_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PAGE_SIZE: page_size_q <= cfg_i.data;
        CFG_ALIGNMENT: alignment_q <= cfg_i.data;
        CFG_MAX_ALLOC: max_alloc_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // allocation state and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q         <= '0;
      active_page_q <= '0;
      cursor_q      <= '0;
      recording_q   <= 1'b0;
      count_q       <= '0;
      sum_req_q     <= '0;
      sum_res_q     <= '0;
      pages_q       <= '0;
      peak_res_q    <= '0;
      peak_pages_q  <= '0;
      ok_q          <= 1'b0;
      grant_q       <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            ok_q    <= 1'b0;
            grant_q <= 1'b0;
            case (req_i.kind)
              KIND_BEGIN: begin
                gen_q         <= gen_inc;
                active_page_q <= '0;
                cursor_q      <= '0;
                recording_q   <= cfg_ok;
                count_q       <= '0;
                sum_req_q     <= '0;
                sum_res_q     <= '0;
                pages_q       <= '0;
                ok_q          <= 1'b1;
              end
              KIND_END: begin
                recording_q <= 1'b0;
                ok_q        <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_COMMIT: begin
          active_page_q <= work_page_q;
          cursor_q      <= off_q + res_q;
          count_q       <= count_q + WORD_W'(1);
          sum_req_q     <= sum_req_q + WIDE_W'(size_q);
          sum_res_q     <= sum_res_q + WIDE_W'(res_q);
          if (used > pages_q) begin
            pages_q <= used;
          end
          ok_q    <= 1'b1;
          grant_q <= 1'b1;
        end
        ST_PEAK: begin
          if (sum_res_q > peak_res_q) begin
            peak_res_q <= sum_res_q;
          end
          if (pages_q > peak_pages_q) begin
            peak_pages_q <= pages_q;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          size_q <= req_i.request_size;
        end
      end
      ST_RND_SIZE: res_q <= rnd_val;
      ST_RND_CUR:  off_q <= rnd_val;
      ST_FIT: begin
        if (fits) begin
          work_page_q <= active_page_q;
        end else begin
          work_page_q <= active_page_q + WORD_W'(1);
          off_q       <= '0;
        end
      end
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load_out) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_ok_q         <= ok_q;
      out_page_q       <= grant_q ? work_page_q : '0;
      out_off_q        <= grant_q ? off_q : '0;
      out_res_q        <= grant_q ? res_q : '0;
      out_gen_q        <= gen_q;
      out_count_q      <= count_q;
      out_sum_req_q    <= sum_req_q;
      out_sum_res_q    <= sum_res_q;
      out_pages_q      <= pages_q;
      out_peak_res_q   <= peak_res_q;
      out_peak_pages_q <= peak_pages_q;
      out_rec_q        <= recording_q;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.ok               = out_ok_q;
  assign rsp_o.page             = out_page_q;
  assign rsp_o.offset           = out_off_q;
  assign rsp_o.reserved_size    = out_res_q;
  assign rsp_o.generation       = out_gen_q;
  assign rsp_o.allocation_count = out_count_q;
  assign rsp_o.requested_total  = out_sum_req_q;
  assign rsp_o.reserved_total   = out_sum_res_q;
  assign rsp_o.pages_used       = out_pages_q;
  assign rsp_o.peak_reserved    = out_peak_res_q;
  assign rsp_o.peak_pages       = out_peak_pages_q;
  assign rsp_o.recording_on     = out_rec_q;

endmodule
`default_nettype wire

@@ hdl/pba_chk.sv @@
// port-level checks of the paged bump allocator and their binding
`timescale 1ns / 1ps
`default_nettype none
module pba_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       req_valid_i,
  input wire logic                       req_ready_i,
  input wire logic                       rsp_valid_i,
  input wire logic                       rsp_ready_i,
  input wire logic                       rsp_ok_i,
  input wire logic [pba_pkg::WORD_W-1:0] rsp_page_i,
  input wire logic [pba_pkg::WORD_W-1:0] rsp_offset_i,
  input wire logic [pba_pkg::WORD_W-1:0] rsp_res_i,
  input wire logic [pba_pkg::WIDE_W-1:0] rsp_gen_i,
  input wire logic [pba_pkg::WORD_W-1:0] rsp_pages_i,
  input wire logic [pba_pkg::WORD_W-1:0] rsp_peak_pages_i,
  input wire logic                       rsp_rec_i
);
  import pba_pkg::*;

  // a pending result stays until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // one request at a time
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  // recording implies a begin has given a nonzero generation
  a_gen_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_rec_i |-> rsp_gen_i != '0)
    else $error("recording with zero generation");

  // a refused request carries no grant
  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ok_i |->
      rsp_page_i == '0 && rsp_offset_i == '0 && rsp_res_i == '0)
    else $error("grant fields set on failure");

  // the page peak never trails the current page count
  a_peak_pages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_peak_pages_i >= rsp_pages_i)
    else $error("page peak below pages used");

endmodule

bind paged_bump_allocator_top pba_chk u_pba_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_ok_i         (rsp_o.ok),
  .rsp_page_i       (rsp_o.page),
  .rsp_offset_i     (rsp_o.offset),
  .rsp_res_i        (rsp_o.reserved_size),
  .rsp_gen_i        (rsp_o.generation),
  .rsp_pages_i      (rsp_o.pages_used),
  .rsp_peak_pages_i (rsp_o.peak_pages),
  .rsp_rec_i        (rsp_o.recording_on)
);
`default_nettype wire
